// ===== rtl/bfcm_pkg.sv =====
package bfcm_pkg;

    localparam int NUM_BANKS    = 16;
    localparam int BANK_BYTES   = 65536;
    localparam int SECTOR_BYTES = 32768;

    localparam int BANK_W       = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int ROWS         = NUM_BANKS * (BANK_BYTES / 4);
    localparam int ROW_W        = $clog2(ROWS);
    localparam int SEC_PER_BANK = (BANK_BYTES + SECTOR_BYTES - 1) / SECTOR_BYTES;

    localparam logic [15:0] UNLOCK_ADDR_A = 16'(16'h555 * 2);
    localparam logic [15:0] UNLOCK_ADDR_B = 16'(16'h2AA * 2);
    localparam logic [7:0]  UNLOCK_KEY_A  = 8'hAA;
    localparam logic [7:0]  UNLOCK_KEY_B  = 8'h55;

    localparam logic [7:0] CMD_ID          = 8'h90;
    localparam logic [7:0] CMD_ID_EXIT     = 8'hF0;
    localparam logic [7:0] CMD_ERASE_ALL   = 8'h10;
    localparam logic [7:0] CMD_ERASE_SETUP = 8'h80;
    localparam logic [7:0] CMD_SECTOR      = 8'h30;
    localparam logic [7:0] CMD_PROGRAM     = 8'hA0;
    localparam logic [7:0] CMD_BANK        = 8'hB0;
    localparam logic [7:0] CMD_BUFFER      = 8'h25;

    localparam logic [15:0] CHIP_ID = {8'h22, 8'h3D};

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;

    typedef logic [ROW_W-1:0] t_row;

    typedef enum logic [1:0] {
        PH_READY,
        PH_CMD1,
        PH_CMD2,
        PH_BUFFER
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_WR1,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic            en;
        t_row            row;
        logic [3:0]      be;
        logic [3:0][7:0] data;
    } t_wr_req;

    typedef struct packed {
        logic en;
        t_row row;
    } t_rd_req;

    typedef struct packed {
        logic       start;
        t_row       first_row;
        t_row       last_row;
        logic [3:0] first_be;
        logic [3:0] last_be;
    } t_clr_req;

    function automatic logic [15:0] sector_start(input logic [15:0] off);
        logic [16:0] s;
        s = '0;
        for (int k = 0; k < SEC_PER_BANK; k++) begin
            if ({1'b0, off} >= 17'(k * SECTOR_BYTES)) begin
                s = 17'(k * SECTOR_BYTES);
            end
        end
        return s[15:0];
    endfunction

endpackage

// ===== rtl/bfcm_store.sv =====
module bfcm_store (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bfcm_pkg::t_wr_req        i_wr,
    input  bfcm_pkg::t_rd_req        i_rd,
    input  bfcm_pkg::t_clr_req       i_clr,
    output logic [3:0][7:0]          o_rd_data,
    output logic                     o_busy
);
    import bfcm_pkg::*;

    logic [3:0][7:0] r_mem [ROWS];
    logic [3:0][7:0] r_rd_data;

    logic       r_busy;
    logic       r_is_first;
    t_row       r_row;
    t_row       r_last;
    logic [3:0] r_first_be;
    logic [3:0] r_last_be;

    logic            w_en;
    t_row            w_row;
    logic [3:0]      w_be;
    logic [3:0][7:0] w_data;

    // erase sweep, one row per cycle, also run out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_is_first <= 1'b1;
            r_row      <= '0;
            r_last     <= ROW_W'(ROWS - 1);
            r_first_be <= 4'hF;
            r_last_be  <= 4'hF;
        end else if (i_clr.start) begin
            r_busy     <= 1'b1;
            r_is_first <= 1'b1;
            r_row      <= i_clr.first_row;
            r_last     <= i_clr.last_row;
            r_first_be <= i_clr.first_be;
            r_last_be  <= i_clr.last_be;
        end else if (r_busy) begin
            r_is_first <= 1'b0;
            if (r_row == r_last) begin
                r_busy <= 1'b0;
            end else begin
                r_row <= ROW_W'(r_row + 1'b1);
            end
        end
    end

    always_comb begin
        if (r_busy) begin
            w_en   = 1'b1;
            w_row  = r_row;
            w_be   = (r_is_first ? r_first_be : 4'hF) & ((r_row == r_last) ? r_last_be : 4'hF);
            w_data = '1;
        end else begin
            w_en   = i_wr.en;
            w_row  = i_wr.row;
            w_be   = i_wr.be;
            w_data = i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 4; l++) begin
                if (w_be[l]) begin
                    r_mem[w_row][l] <= w_data[l];
                end
            end
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.row];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

// ===== rtl/banked_flash_command_machine.sv =====
// Banked NOR flash with an unlock-sequence command decoder. The store is one memory of
// 4-byte rows (NUM_BANKS * 16384 rows) with a write port and a registered read port. A
// read issues its row read on accept and is packed in ST_RD0, or in ST_RD1 after a second
// row read when it crosses a row boundary; in ID mode the ID goes through ST_HOLD. A
// write stores its row on accept, and a second row in ST_WR1 when it crosses a row
// boundary. After reset and after an erase-all command a sweep writes 0xFF over every
// row, during which no word is accepted; a sector erase sweeps the rows of one sector.
// A finished read waits in the output register while the next word is taken in.
module banked_flash_command_machine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // access_size[1:0], offset[17:2], write_data[49:18], zero fill
    input  logic [55:0] s_axis_tdata,
    // opcode[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[31:0]
    output logic [31:0] m_axis_tdata
);
    import bfcm_pkg::*;

    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [7:0]          r_cmd, n_cmd;
    logic [BANK_W-1:0]   r_bank, n_bank;
    logic [16:0]         r_words_left, n_words_left;
    logic [1:0]          r_lane, n_lane;
    logic [2:0]          r_n, n_n;
    t_row                r_row1, n_row1;
    logic [3:0]          r_be1, n_be1;
    logic [3:0][7:0]     r_wdata, n_wdata;
    logic [3:0][7:0]     r_row0_q, n_row0_q;
    logic [31:0]         r_hold, n_hold;
    logic                r_out_valid, n_out_valid;
    logic [31:0]         r_out_data, n_out_data;

    t_wr_req         wr;
    t_rd_req         rd;
    t_clr_req        clr;
    logic [3:0][7:0] rd_data;
    logic            busy;

    logic            accept;
    logic            out_free;
    logic            in_op;
    logic [1:0]      in_size;
    logic [15:0]     in_off;
    logic [31:0]     in_raw;
    logic [2:0]      in_n;
    logic [31:0]     in_v;
    logic [1:0]      in_lane;
    t_row            in_row0;
    t_row            in_row1;
    logic [3:0]      in_be0;
    logic [3:0]      in_be1;
    logic [3:0][7:0] in_wdata;
    logic            in_span;
    logic            r_span;
    logic            do_store;
    logic [15:0]     sec_start;
    logic [16:0]     sec_end;
    logic [15:0]     sec_last;
    logic [31:0]     rd_value;

    function automatic logic [31:0] rd_pack(input logic [3:0][7:0] lo,
                                            input logic [3:0][7:0] hi,
                                            input logic [1:0] s,
                                            input logic [2:0] n);
        logic [1:0]  l;
        logic [31:0] v;
        v = '0;
        for (int i = 0; i < 4; i++) begin
            l = s + 2'(i);
            if (3'(i) < n) begin
                v[8*i +: 8] = (l >= s) ? lo[l] : hi[l];
            end
        end
        return v;
    endfunction

    bfcm_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_rd      (rd),
        .i_clr     (clr),
        .o_rd_data (rd_data),
        .o_busy    (busy)
    );

    assign s_axis_tready = (r_state == ST_IDLE) && !busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign in_op   = s_axis_tuser;
    assign in_size = s_axis_tdata[1:0];
    assign in_off  = s_axis_tdata[17:2];
    assign in_raw  = s_axis_tdata[49:18];
    assign in_lane = in_off[1:0];

    always_comb begin
        unique case (in_size)
            SZ_BYTE: begin
                in_n = 3'd1;
                in_v = {24'd0, in_raw[7:0]};
            end
            SZ_HALF: begin
                in_n = 3'd2;
                in_v = {16'd0, in_raw[15:0]};
            end
            default: begin
                in_n = 3'd4;
                in_v = in_raw;
            end
        endcase
    end

    assign in_row0 = ROW_W'({r_bank, in_off[15:2]});
    assign in_row1 = (in_row0 == ROW_W'(ROWS - 1)) ? '0 : ROW_W'(in_row0 + 1'b1);
    assign in_span = (3'(in_lane) + in_n) > 3'd4;
    assign r_span  = (3'(r_lane) + r_n) > 3'd4;

    // lane l of a row holds byte (l - lane) of the word
    always_comb begin
        logic [1:0] idx;
        for (int l = 0; l < 4; l++) begin
            idx         = 2'(l) - in_lane;
            in_wdata[l] = in_v[8*idx +: 8];
            in_be0[l]   = (3'(idx) < in_n) && (2'(l) >= in_lane);
            in_be1[l]   = (3'(idx) < in_n) && (2'(l) < in_lane);
        end
    end

    assign sec_start = sector_start(in_off);
    assign sec_end   = ((17'(sec_start) + 17'(SECTOR_BYTES)) > 17'(BANK_BYTES)) ?
                       17'(BANK_BYTES) : (17'(sec_start) + 17'(SECTOR_BYTES));
    assign sec_last  = 16'(sec_end - 17'd1);

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_cmd        = r_cmd;
        n_bank       = r_bank;
        n_words_left = r_words_left;
        n_lane       = r_lane;
        n_n          = r_n;
        n_row1       = r_row1;
        n_be1        = r_be1;
        n_wdata      = r_wdata;
        n_row0_q     = r_row0_q;
        n_hold       = r_hold;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_data   = r_out_data;
        wr           = '0;
        rd           = '0;
        clr          = '0;
        do_store     = 1'b0;
        rd_value     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_lane  = in_lane;
                    n_n     = in_n;
                    n_row1  = in_row1;
                    n_be1   = in_be1;
                    n_wdata = in_wdata;
                    if (!in_op) begin
                        if (r_cmd == CMD_ID) begin
                            n_hold  = (in_n == 3'd1) ? 32'd0 : {16'd0, CHIP_ID};
                            n_state = ST_HOLD;
                        end else begin
                            rd.en   = 1'b1;
                            rd.row  = in_row0;
                            n_state = ST_RD0;
                        end
                    end else begin
                        unique case (r_phase)
                            PH_READY: begin
                                if (in_v == 32'(UNLOCK_KEY_A) && in_off == UNLOCK_ADDR_A) begin
                                    n_phase = PH_CMD1;
                                end else if (in_off == 16'd0 && in_v == 32'(CMD_ID_EXIT)) begin
                                    n_phase = PH_READY;
                                end else if (r_cmd == CMD_BANK) begin
                                    n_bank = (in_v >= 32'(NUM_BANKS)) ? '0 : BANK_W'(in_v);
                                end else if (r_cmd == CMD_PROGRAM) begin
                                    do_store = 1'b1;
                                end
                            end
                            PH_CMD1: begin
                                n_phase = (in_v == 32'(UNLOCK_KEY_B) && in_off == UNLOCK_ADDR_B) ?
                                          PH_CMD2 : PH_READY;
                            end
                            PH_CMD2: begin
                                n_phase = PH_READY;
                                if (in_off == UNLOCK_ADDR_A) begin
                                    n_cmd = in_v[7:0];
                                    if (in_v[7:0] == CMD_ERASE_ALL) begin
                                        clr.start     = 1'b1;
                                        clr.first_row = '0;
                                        clr.last_row  = ROW_W'(ROWS - 1);
                                        clr.first_be  = 4'hF;
                                        clr.last_be   = 4'hF;
                                    end
                                end else if (in_v == 32'(CMD_SECTOR) && r_cmd == CMD_ERASE_SETUP) begin
                                    clr.start     = 1'b1;
                                    clr.first_row = ROW_W'({r_bank, sec_start[15:2]});
                                    clr.last_row  = ROW_W'({r_bank, sec_last[15:2]});
                                    clr.first_be  = 4'hF << sec_start[1:0];
                                    clr.last_be   = 4'hF >> (2'd3 - sec_last[1:0]);
                                end else if (in_v == 32'(CMD_BUFFER)) begin
                                    n_cmd   = CMD_BUFFER;
                                    n_phase = PH_CMD2;
                                end else if (r_cmd == CMD_BUFFER) begin
                                    n_phase      = PH_BUFFER;
                                    n_words_left = 17'(in_v[15:0]) + 17'd1;
                                end
                            end
                            PH_BUFFER: begin
                                if (r_words_left != 17'd0) begin
                                    n_words_left = 17'(r_words_left - 17'd1);
                                    do_store     = 1'b1;
                                end else begin
                                    n_phase = PH_READY;
                                end
                            end
                            default: begin
                                n_phase = PH_READY;
                            end
                        endcase
                        if (do_store) begin
                            wr.en   = 1'b1;
                            wr.row  = in_row0;
                            wr.be   = in_be0;
                            wr.data = in_wdata;
                            if (in_span) begin
                                n_state = ST_WR1;
                            end
                        end
                    end
                end
            end
            ST_WR1: begin
                wr.en   = 1'b1;
                wr.row  = r_row1;
                wr.be   = r_be1;
                wr.data = r_wdata;
                n_state = ST_IDLE;
            end
            ST_RD0: begin
                if (r_span) begin
                    n_row0_q = rd_data;
                    rd.en    = 1'b1;
                    rd.row   = r_row1;
                    n_state  = ST_RD1;
                end else begin
                    rd_value = rd_pack(rd_data, rd_data, r_lane, r_n);
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_data  = rd_value;
                        n_state     = ST_IDLE;
                    end else begin
                        n_hold  = rd_value;
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_RD1: begin
                rd_value = rd_pack(r_row0_q, rd_data, r_lane, r_n);
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = rd_value;
                    n_state     = ST_IDLE;
                end else begin
                    n_hold  = rd_value;
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_hold;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase      <= PH_READY;
            r_cmd        <= '0;
            r_bank       <= '0;
            r_words_left <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_cmd        <= n_cmd;
            r_bank       <= n_bank;
            r_words_left <= n_words_left;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane     <= n_lane;
        r_n        <= n_n;
        r_row1     <= n_row1;
        r_be1      <= n_be1;
        r_wdata    <= n_wdata;
        r_row0_q   <= n_row0_q;
        r_hold     <= n_hold;
        r_out_data <= n_out_data;
    end

endmodule
